// ===== rtl/dary_heap_priority_queue_core_macros.svh =====
// Assertion helpers for the heap core.
// DHPQ_ASSERT_IMPLY: same-cycle implication. DHPQ_ASSERT_NEXT: next-cycle implication.
`ifndef DARY_HEAP_PRIORITY_QUEUE_CORE_MACROS_SVH
`define DARY_HEAP_PRIORITY_QUEUE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define DHPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("heap core check failed");
`define DHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("heap core check failed");
`else
`define DHPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/dhpq_pkg.sv =====
`default_nettype none
package dhpq_pkg;

    localparam int ARITY     = 2;
    localparam int CAPACITY  = 1024;
    localparam int KEY_WIDTH = 32;

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int AR_L   = $clog2(ARITY);
    // child indexes run past the last slot before they are range checked
    localparam int CH_W   = CNT_W + AR_L + 1;

    // parent = (pos - 1) / ARITY via reciprocal multiply, exact for IDX_W-bit operands
    localparam int DIV_SH  = IDX_W + AR_L;
    localparam longint unsigned RECIP = ((64'd1 << DIV_SH) + ARITY - 1) / ARITY;
    localparam int RECIP_W = DIV_SH + 1;
    localparam int PROD_W  = IDX_W + RECIP_W;

    localparam int IN_OP_W     = 2;
    localparam int IN_VALUE_W  = 32;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_TOP_W   = 32;
    localparam int OUT_COUNT_W = 11;
    localparam int OUT_FAULT_W = 2;
    localparam int OUT_DATA_W  = 48;

    localparam logic [IN_OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [IN_OP_W-1:0] OP_POP  = 2'd1;

    localparam logic [OUT_FAULT_W-1:0] FAULT_OK        = 2'd0;
    localparam logic [OUT_FAULT_W-1:0] FAULT_POP_EMPTY = 2'd1;
    localparam logic [OUT_FAULT_W-1:0] FAULT_PUSH_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_NODE,
        S_DN_CH,
        S_DN_DEC,
        S_DONE
    } t_state;

    function automatic logic [IDX_W-1:0] f_parent(input logic [IDX_W-1:0] pos);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(pos - IDX_W'(1)) * PROD_W'(RECIP);
        return IDX_W'(prod >> DIV_SH);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/dhpq_ram.sv =====
`default_nettype none
module dhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/dary_heap_priority_queue_core.sv =====
// Steps per transaction: a query, a pop on empty or a push when full goes straight to
// the result. A push reads and compares one parent per step until the key settles, the
// root included. A pop reads the last slot, then per level reads each existing child in
// turn and compares the best with the key, until the key settles in a node.
// One transaction in flight; s_axis_tready is high only when idle. A held result adds stalls.
// Reset (sync, active low): empties the heap, order returns to largest first, output
// register empties. Heap RAM is not cleared; only slots below the count are read.
`default_nettype none
`include "dary_heap_priority_queue_core_macros.svh"
module dary_heap_priority_queue_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [1:0] operation, [33:2] value, [39:34] zero
    input  wire logic [dhpq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [31:0] top_value, [42:32] count, [43] is_empty, [45:44] fault, [47:46] zero
    output logic      [dhpq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                            i_cfg_we,
    input  wire logic [0:0]                      i_cfg_wdata
);

    localparam int IDX_W = dhpq_pkg::IDX_W;
    localparam int CNT_W = dhpq_pkg::CNT_W;
    localparam int CH_W  = dhpq_pkg::CH_W;
    localparam int KEY_W = dhpq_pkg::KEY_WIDTH;

    dhpq_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]  r_count, n_count;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic [CH_W-1:0]   r_ch, n_ch;
    logic [CH_W-1:0]   r_end, n_end;
    logic [CH_W-1:0]   r_best, n_best;
    logic [KEY_W-1:0]  r_bestv, n_bestv;
    logic              r_first, n_first;
    logic [dhpq_pkg::OUT_FAULT_W-1:0] r_fault, n_fault;
    logic [KEY_W-1:0]  r_top;
    logic              r_lf;
    logic              r_ovalid, n_ovalid;
    logic [dhpq_pkg::OUT_DATA_W-1:0] r_odata, n_odata;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [KEY_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [KEY_W-1:0]  ram_rdata;

    logic [KEY_W-1:0]  cmp_a, cmp_b;
    logic              ahead;
    logic              s_acc;
    logic [dhpq_pkg::IN_OP_W-1:0] in_op;
    logic [KEY_W-1:0]  in_key;
    logic [CH_W-1:0]   count_x;
    logic [CH_W-1:0]   first_ch;
    logic [CH_W-1:0]   next_ch;
    logic [KEY_W-1:0]  top_out;

    dhpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (dhpq_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == dhpq_pkg::S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign in_op         = s_axis_tdata[dhpq_pkg::IN_OP_W-1:0];
    assign in_key        = KEY_W'(s_axis_tdata[dhpq_pkg::IN_OP_W +: dhpq_pkg::IN_VALUE_W]);
    assign count_x       = CH_W'(r_count);
    assign first_ch      = CH_W'(r_pos) * CH_W'(dhpq_pkg::ARITY) + CH_W'(1);
    assign next_ch       = r_ch + CH_W'(1);
    assign top_out       = (r_count != '0) ? r_top : '0;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // shared key comparator: true when cmp_a belongs strictly nearer the top
    always_comb begin
        case (r_state)
            dhpq_pkg::S_UP_CMP: begin
                cmp_a = r_key;
                cmp_b = ram_rdata;
            end
            dhpq_pkg::S_DN_CH: begin
                cmp_a = r_bestv;
                cmp_b = ram_rdata;
            end
            default: begin
                cmp_a = r_bestv;
                cmp_b = r_key;
            end
        endcase
        ahead = r_lf ? (cmp_a > cmp_b) : (cmp_a < cmp_b);
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_key     = r_key;
        n_pos     = r_pos;
        n_ch      = r_ch;
        n_end     = r_end;
        n_best    = r_best;
        n_bestv   = r_bestv;
        n_first   = r_first;
        n_fault   = r_fault;
        n_ovalid  = r_ovalid && !m_axis_tready;
        n_odata   = r_odata;
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = r_key;
        ram_raddr = '0;

        case (r_state)
            dhpq_pkg::S_IDLE: begin
                if (s_acc) begin
                    n_fault = dhpq_pkg::FAULT_OK;
                    n_state = dhpq_pkg::S_DONE;
                    if (in_op == dhpq_pkg::OP_PUSH) begin
                        if (r_count == CNT_W'(dhpq_pkg::CAPACITY)) begin
                            n_fault = dhpq_pkg::FAULT_PUSH_FULL;
                        end else begin
                            n_key   = in_key;
                            n_pos   = IDX_W'(r_count);
                            n_count = r_count + CNT_W'(1);
                            n_state = dhpq_pkg::S_UP;
                        end
                    end else if (in_op == dhpq_pkg::OP_POP) begin
                        if (r_count == '0) begin
                            n_fault = dhpq_pkg::FAULT_POP_EMPTY;
                        end else begin
                            ram_raddr = IDX_W'(r_count - CNT_W'(1));
                            n_count   = r_count - CNT_W'(1);
                            n_state   = dhpq_pkg::S_DN_LAST;
                        end
                    end
                end
            end
            dhpq_pkg::S_UP: begin
                if (r_pos == '0) begin
                    ram_we  = 1'b1;
                    n_state = dhpq_pkg::S_DONE;
                end else begin
                    ram_raddr = dhpq_pkg::f_parent(r_pos);
                    n_ch      = CH_W'(dhpq_pkg::f_parent(r_pos));
                    n_state   = dhpq_pkg::S_UP_CMP;
                end
            end
            dhpq_pkg::S_UP_CMP: begin
                ram_we = 1'b1;
                if (ahead) begin
                    // parent moves down into the hole
                    ram_wdata = ram_rdata;
                    n_pos     = IDX_W'(r_ch);
                    n_state   = dhpq_pkg::S_UP;
                end else begin
                    n_state = dhpq_pkg::S_DONE;
                end
            end
            dhpq_pkg::S_DN_LAST: begin
                n_key   = ram_rdata;
                n_pos   = '0;
                n_state = (r_count == '0) ? dhpq_pkg::S_DONE : dhpq_pkg::S_DN_NODE;
            end
            dhpq_pkg::S_DN_NODE: begin
                if (first_ch >= count_x) begin
                    ram_we  = 1'b1;
                    n_state = dhpq_pkg::S_DONE;
                end else begin
                    ram_raddr = IDX_W'(first_ch);
                    n_ch      = first_ch;
                    n_end     = first_ch + CH_W'(dhpq_pkg::ARITY);
                    n_first   = 1'b1;
                    n_state   = dhpq_pkg::S_DN_CH;
                end
            end
            dhpq_pkg::S_DN_CH: begin
                n_first = 1'b0;
                // later child wins a tie
                if (r_first || !ahead) begin
                    n_bestv = ram_rdata;
                    n_best  = r_ch;
                end
                if (next_ch < count_x && next_ch < r_end) begin
                    ram_raddr = IDX_W'(next_ch);
                    n_ch      = next_ch;
                end else begin
                    n_state = dhpq_pkg::S_DN_DEC;
                end
            end
            dhpq_pkg::S_DN_DEC: begin
                ram_we = 1'b1;
                if (ahead) begin
                    ram_wdata = r_bestv;
                    n_pos     = IDX_W'(r_best);
                    n_state   = dhpq_pkg::S_DN_NODE;
                end else begin
                    n_state = dhpq_pkg::S_DONE;
                end
            end
            dhpq_pkg::S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {2'b00, r_fault, (r_count == '0),
                                dhpq_pkg::OUT_COUNT_W'(r_count),
                                dhpq_pkg::OUT_TOP_W'(top_out)};
                    n_state  = dhpq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dhpq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dhpq_pkg::S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_lf     <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_lf <= i_cfg_wdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_pos   <= n_pos;
        r_ch    <= n_ch;
        r_end   <= n_end;
        r_best  <= n_best;
        r_bestv <= n_bestv;
        r_first <= n_first;
        r_fault <= n_fault;
        r_odata <= n_odata;
        // root shadow for the result
        if (ram_we && ram_waddr == '0) begin
            r_top <= ram_wdata;
        end
    end

    `DHPQ_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(dhpq_pkg::CAPACITY))
    `DHPQ_ASSERT_NEXT(a_pop_empty, i_clk, i_rst_n,
        s_acc && in_op == dhpq_pkg::OP_POP && r_count == '0,
        r_state == dhpq_pkg::S_DONE && r_fault == dhpq_pkg::FAULT_POP_EMPTY)
    `DHPQ_ASSERT_NEXT(a_push_count, i_clk, i_rst_n,
        s_acc && in_op == dhpq_pkg::OP_PUSH && r_count != CNT_W'(dhpq_pkg::CAPACITY),
        r_count == $past(r_count) + CNT_W'(1))
    `DHPQ_ASSERT_NEXT(a_root_shadow, i_clk, i_rst_n,
        ram_we && ram_waddr == '0,
        r_top == $past(ram_wdata))

endmodule
`default_nettype wire
